// ===== hw/rtl/mp3s2_pkg.sv =====
// Shared types, constants and helper functions for the 3x3 stride-2 max pool.
`timescale 1ns / 1ps

package mp3s2_pkg;

    // Default depth of the column-max line
    localparam int MAX_WIDTH_DEF = 256;

    // Register map indexes (byte address = 4 * index)
    localparam logic [1:0] REG_IN_WIDTH      = 2'd0;
    localparam logic [1:0] REG_OUT_WIDTH     = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] IN_WIDTH_RST      = 8'd113;
    localparam logic [6:0] OUT_WIDTH_RST     = 7'd56;
    localparam logic [9:0] CHANNEL_COUNT_RST = 10'd64;

    localparam logic [30:0] INF_BITS = 31'h7F80_0000;

    typedef struct packed {
        logic [7:0] in_width;
        logic [6:0] out_width;
        logic [9:0] channel_count;
    } t_cfg;

    // One pixel on its way through the pipe, with its plane position
    typedef struct packed {
        logic [30:0] pix;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [9:0]  plane;
    } t_item;

    // Negative and NaN pixels count as zero
    function automatic logic [30:0] clean_pixel(input logic [31:0] bits);
        logic [30:0] mag;
        mag = bits[30:0];
        if (bits[31] || (mag > INF_BITS)) begin
            return '0;
        end
        return mag;
    endfunction

    function automatic logic [30:0] max31(input logic [30:0] a, input logic [30:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== hw/rtl/mp3s2_cfg.sv =====
// APB register block holding plane size, pooled size and channel count.
`timescale 1ns / 1ps

module mp3s2_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mp3s2_pkg::t_cfg    o_cfg
);

    mp3s2_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_width      <= mp3s2_pkg::IN_WIDTH_RST;
            r_cfg.out_width     <= mp3s2_pkg::OUT_WIDTH_RST;
            r_cfg.channel_count <= mp3s2_pkg::CHANNEL_COUNT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                mp3s2_pkg::REG_IN_WIDTH:      r_cfg.in_width      <= pwdata[7:0];
                mp3s2_pkg::REG_OUT_WIDTH:     r_cfg.out_width     <= pwdata[6:0];
                mp3s2_pkg::REG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            mp3s2_pkg::REG_IN_WIDTH:      prdata = {24'd0, r_cfg.in_width};
            mp3s2_pkg::REG_OUT_WIDTH:     prdata = {25'd0, r_cfg.out_width};
            mp3s2_pkg::REG_CHANNEL_COUNT: prdata = {22'd0, r_cfg.channel_count};
            default:                      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/mp3s2_line_mem.sv =====
// Column-max line buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module mp3s2_line_mem #(
    parameter int MAX_WIDTH = mp3s2_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [30:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [30:0]   i_wr_data
);

    logic [30:0] mem [MAX_WIDTH];
    logic [30:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/mp3s2_window.sv =====
// Window stage: vertical and horizontal max, result flags and output register.
`timescale 1ns / 1ps

module mp3s2_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mp3s2_pkg::t_cfg    i_cfg,
    input  logic               i_valid,
    input  mp3s2_pkg::t_item   i_item,
    input  logic [30:0]        i_stored,
    output logic               o_adv,
    output logic [30:0]        o_wr_data,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [31:0]        o_m_axis_tdata,
    output logic               o_m_axis_tlast,
    output logic               o_m_axis_tuser
);

    logic [30:0] r_hmax, n_hmax;
    logic        r_out_valid;
    logic [30:0] r_out_bits;
    logic        r_out_eop, r_out_eol;

    logic        row_odd, row_closes, col_odd, col_closes;
    logic [30:0] vmax, v, m;
    logic [6:0]  y, x, last_pos;
    logic [9:0]  last_plane;
    logic        emit, eop, eol;

    assign o_adv = i_valid && (!r_out_valid || i_m_axis_tready);

    // Vertical max over the open window rows
    always_comb begin
        row_odd    = i_item.row[0];
        row_closes = !i_item.row[0] && (i_item.row >= 8'd2);
        col_odd    = i_item.col[0];
        col_closes = !i_item.col[0] && (i_item.col >= 8'd2);
        vmax       = mp3s2_pkg::max31(i_stored, i_item.pix);
        v          = (row_closes || row_odd) ? vmax : i_item.pix;
        o_wr_data  = row_odd ? v : i_item.pix;
    end

    // Horizontal max and result decision
    always_comb begin
        y          = i_item.row[7:1] - 7'd1;
        x          = i_item.col[7:1] - 7'd1;
        last_pos   = i_cfg.out_width - 7'd1;
        last_plane = i_cfg.channel_count - 10'd1;
        m          = mp3s2_pkg::max31(r_hmax, v);
        emit       = row_closes && col_closes
                     && (y < i_cfg.out_width) && (x < i_cfg.out_width);
        eop        = (y == last_pos) && (x == last_pos);
        eol        = eop && (i_item.plane == last_plane);
        n_hmax     = r_hmax;
        if (row_closes) begin
            if (col_closes) begin
                n_hmax = v;
            end else if (col_odd) begin
                n_hmax = m;
            end else begin
                n_hmax = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hmax      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_hmax <= n_hmax;
            end
            if (o_adv && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_adv && emit) begin
            r_out_bits <= m;
            r_out_eop  <= eop;
            r_out_eol  <= eol;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_bits};
    assign o_m_axis_tlast  = r_out_eop;
    assign o_m_axis_tuser  = r_out_eol;

endmodule

// ===== hw/rtl/max_pool_3x3_stride2.sv =====
// A window's last pixel enters the stage-1 register, its result the output register.
// Throughput: one pixel per cycle, one line-buffer read and one write per pixel.
// Stalls on the output back up to the input only when the output register is full.
// Reset (synchronous, active low) clears positions, running max and valids, and loads
// the registers with 113 / 56 / 64; the line buffer is not cleared.
`timescale 1ns / 1ps

module max_pool_3x3_stride2 #(
    parameter int MAX_WIDTH = mp3s2_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] pixel_bits
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [30:0] pooled_bits, [31] zero
    output logic        o_m_axis_tlast,   // end_of_plane
    output logic        o_m_axis_tuser,   // [0] end_of_layer
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = 12;

    mp3s2_pkg::t_cfg  cfg;
    mp3s2_pkg::t_item r_s1_item;
    logic             r_s1_valid;
    logic [7:0]       r_row, r_col, n_row, n_col;
    logic [9:0]       r_plane, n_plane;
    logic             r_fwd;
    logic [30:0]      r_fwd_data;
    logic             accept, adv;
    logic             in_col_ok, s1_col_ok;
    logic [30:0]      rd_data, stored, wr_data;
    logic [7:0]       last_col;
    logic [9:0]       last_plane;

    mp3s2_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_s_axis_tready = !r_s1_valid || adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_col_ok       = CW'(r_col) < CW'(MAX_WIDTH);
    assign s1_col_ok       = CW'(r_s1_item.col) < CW'(MAX_WIDTH);

    // Raster position of the next pixel
    always_comb begin
        last_col   = cfg.in_width - 8'd1;
        last_plane = cfg.channel_count - 10'd1;
        n_row      = r_row;
        n_col      = r_col + 8'd1;
        n_plane    = r_plane;
        if (r_col >= last_col) begin
            n_col = '0;
            if (r_row >= last_col) begin
                n_row   = '0;
                n_plane = (r_plane >= last_plane) ? 10'd0 : r_plane + 10'd1;
            end else begin
                n_row = r_row + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_plane    <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_plane <= n_plane;
                // Same column written on this edge: memory returns the old word
                r_fwd   <= adv && s1_col_ok && (r_col == r_s1_item.col);
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Stage-1 payload and forwarded line word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item.pix   <= mp3s2_pkg::clean_pixel(i_s_axis_tdata);
            r_s1_item.row   <= r_row;
            r_s1_item.col   <= r_col;
            r_s1_item.plane <= r_plane;
            r_fwd_data      <= wr_data;
        end
    end

    mp3s2_line_mem #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (accept && in_col_ok),
        .i_rd_addr (AW'(r_col)),
        .o_rd_data (rd_data),
        .i_wr_en   (adv && s1_col_ok),
        .i_wr_addr (AW'(r_s1_item.col)),
        .i_wr_data (wr_data)
    );

    // Columns past the line read as zero
    assign stored = !s1_col_ok ? 31'd0 : (r_fwd ? r_fwd_data : rd_data);

    mp3s2_window u_win (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (r_s1_valid),
        .i_item          (r_s1_item),
        .i_stored        (stored),
        .o_adv           (adv),
        .o_wr_data       (wr_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== hw/rtl/mp3s2_checker.sv =====
// Port-level checker for the max pool block, bound to the top level.
`timescale 1ns / 1ps

module mp3s2_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    // No result beat right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // End of layer only on the end of a plane
    a_layer_on_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("end_of_layer without end_of_plane");

    // Pooled value is a non-negative float, never above infinity
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tdata[31] && (o_m_axis_tdata[30:0] <= 31'h7F80_0000)))
        else $error("pooled value out of range");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
             && $stable(o_m_axis_tuser)))
        else $error("stalled output beat changed");

endmodule

bind max_pool_3x3_stride2 mp3s2_checker u_mp3s2_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the 3x3 stride-2 max pool: stream driver, monitor and predictor.
`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_CYCLES = 8;     // pipe holds the stage-1 and output registers, leave margin
    localparam int STALL_LIMIT  = 4000;  // cycles without any beat or register write before giving up
    localparam int LINE_DEPTH   = 256;

    typedef enum logic [1:0] {
        CMD_PIXEL,  // one pixel beat
        CMD_WRITE,  // one register write
        CMD_DRAIN,  // hold off until every pooled result is back
        CMD_CALM    // no more idling from here on
    } t_cmd_kind;

    // Register write sequencing on the config bus
    typedef enum logic [2:0] {
        APB_IDLE   = 3'b001,
        APB_SETUP  = 3'b010,
        APB_ACCESS = 3'b100
    } t_apb_phase;

    typedef struct {
        t_cmd_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] data;
    } t_stim_cmd;

    typedef struct packed {
        logic [30:0] pooled;
        logic        end_of_plane;
        logic        end_of_layer;
    } t_pooled;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] pixel_bits
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [30:0] pooled_bits, [31] zero
    logic        o_m_axis_tlast;        // end_of_plane
    logic        o_m_axis_tuser;        // [0] end_of_layer
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    max_pool_3x3_stride2 DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 i_clk = ~i_clk;

    t_stim_cmd cmdq[$];
    t_pooled   pooled_q[$];
    int        mismatches = 0;
    logic      calm = 1'b0;
    logic      feed_done = 1'b0;

    // Predictor state: configuration, column maxima, positions, running row max
    logic [7:0]  cfg_in_width = mp3s2_pkg::IN_WIDTH_RST;
    logic [6:0]  cfg_out_width = mp3s2_pkg::OUT_WIDTH_RST;
    logic [9:0]  cfg_channels = mp3s2_pkg::CHANNEL_COUNT_RST;
    logic [30:0] col_max [LINE_DEPTH];
    logic [7:0]  row_pos = '0;
    logic [7:0]  col_pos = '0;
    logic [9:0]  plane_pos = '0;
    logic [30:0] run_max = '0;

    initial begin
        foreach (col_max[i]) col_max[i] = '0;
    end

    function automatic logic [30:0] larger31(input logic [30:0] a, input logic [30:0] b);
        return (a > b) ? a : b;
    endfunction

    // Advance the pooling predictor by one pixel, queue the pooled result if one closes
    task automatic pool_pixel(input logic [31:0] bits);
        logic [30:0] p;
        logic [30:0] stored;
        logic [30:0] v;
        logic        closes;
        logic [7:0]  yy;
        logic [7:0]  xx;
        logic [7:0]  last_col;
        logic [9:0]  last_plane;
        t_pooled     res;
        // negatives and NaNs are flushed to +0
        p = (bits[31] || (bits[30:0] > mp3s2_pkg::INF_BITS)) ? 31'd0 : bits[30:0];
        stored = col_max[col_pos];
        closes = !row_pos[0] && (row_pos >= 8'd2);
        v = (row_pos[0] || closes) ? larger31(stored, p) : p;
        col_max[col_pos] = row_pos[0] ? v : p;
        last_plane = cfg_channels - 10'd1;
        if (closes) begin
            yy = row_pos / 8'd2 - 8'd1;
            if (!col_pos[0] && (col_pos >= 8'd2)) begin
                xx = col_pos / 8'd2 - 8'd1;
                if ((yy < {1'b0, cfg_out_width}) && (xx < {1'b0, cfg_out_width})) begin
                    res.pooled = larger31(run_max, v);
                    res.end_of_plane = (yy == {1'b0, cfg_out_width} - 8'd1) &&
                                       (xx == {1'b0, cfg_out_width} - 8'd1);
                    res.end_of_layer = res.end_of_plane && (plane_pos == last_plane);
                    pooled_q.push_back(res);
                end
                run_max = v;
            end else if (col_pos[0]) begin
                run_max = larger31(run_max, v);
            end else begin
                run_max = v;
            end
        end
        // raster position, counters wrap once at or past their last value
        last_col = cfg_in_width - 8'd1;
        if (col_pos >= last_col) begin
            col_pos = '0;
            if (row_pos >= last_col) begin
                row_pos = '0;
                plane_pos = (plane_pos >= last_plane) ? 10'd0 : plane_pos + 10'd1;
            end else begin
                row_pos = row_pos + 8'd1;
            end
        end else begin
            col_pos = col_pos + 8'd1;
        end
    endtask

    task automatic apply_cfg(input logic [1:0] idx, input logic [31:0] value);
        case (idx)
            mp3s2_pkg::REG_IN_WIDTH:      cfg_in_width = value[7:0];
            mp3s2_pkg::REG_OUT_WIDTH:     cfg_out_width = value[6:0];
            mp3s2_pkg::REG_CHANNEL_COUNT: cfg_channels = value[9:0];
            default: ;
        endcase
    endtask

    // Mix of finite, tied, infinite, NaN and negative pixels
    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return {1'b1, 31'($urandom())};
            2:       return {1'($urandom()), 31'(32'h7F80_0001 + $urandom_range(0, 32'h7F_FFFE))};
            3:       return $urandom_range(0, 1) ? 32'h7F80_0000 : 32'h7F7F_FFFF;
            4:       return $urandom_range(0, 1) ? 32'h0000_0000 : 32'h8000_0000;
            5, 6:    return {1'b0, 31'($urandom_range(0, 32'h7F7F_FFFF))};
            default: return 32'h3F80_0000 + $urandom_range(0, 63);
        endcase
    endfunction

    task automatic push_pixel(input logic [31:0] bits);
        t_stim_cmd c;
        c.kind = CMD_PIXEL;
        c.reg_idx = '0;
        c.data = bits;
        cmdq.push_back(c);
    endtask

    task automatic push_write(input logic [1:0] idx, input logic [31:0] value);
        t_stim_cmd c;
        c.kind = CMD_WRITE;
        c.reg_idx = idx;
        c.data = value;
        cmdq.push_back(c);
    endtask

    task automatic push_mark(input t_cmd_kind kind);
        t_stim_cmd c;
        c.kind = kind;
        c.reg_idx = '0;
        c.data = '0;
        cmdq.push_back(c);
    endtask

    task automatic push_randoms(input int count);
        repeat (count) push_pixel(random_pixel());
    endtask

    // Stimulus plan, then wait for the driver to run dry and judge
    initial begin
        logic [31:0] corner_pix [18];
        int          in_eff;
        int          fit;
        int          outw;
        bit          wrote;
        corner_pix = '{32'h3F80_0000, 32'hBF80_0000, 32'h7FC0_0000, 32'h0000_0001,
                       32'h8000_0000, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
                       32'h7F7F_FFFF,
                       32'h8000_0001, 32'hFF80_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                       32'hC000_0000, 32'h8000_0000, 32'hFFC0_0000, 32'h7F80_0001,
                       32'hBF80_0000};

        // smallest planes: infinity, NaN, negatives, denormal; second plane all flushed
        push_write(mp3s2_pkg::REG_IN_WIDTH, 32'd3);
        push_write(mp3s2_pkg::REG_OUT_WIDTH, 32'd1);
        push_write(mp3s2_pkg::REG_CHANNEL_COUNT, 32'd2);
        foreach (corner_pix[i]) push_pixel(corner_pix[i]);
        push_mark(CMD_DRAIN);

        // first row of a 256-wide plane: every line entry gets written
        push_write(mp3s2_pkg::REG_IN_WIDTH, 32'd0);
        push_write(mp3s2_pkg::REG_OUT_WIDTH, 32'd127);
        push_write(mp3s2_pkg::REG_CHANNEL_COUNT, 32'd1);
        push_randoms(256);
        push_mark(CMD_DRAIN);

        // widest register value from the second row on, into the first window row
        push_write(mp3s2_pkg::REG_IN_WIDTH, 32'd255);
        push_randoms(276);
        push_mark(CMD_DRAIN);

        // tiny planes in a 1024-plane layer, then a 1023-plane one
        push_write(mp3s2_pkg::REG_IN_WIDTH, 32'd3);
        push_write(mp3s2_pkg::REG_OUT_WIDTH, 32'd1);
        push_write(mp3s2_pkg::REG_CHANNEL_COUNT, 32'd0);
        push_randoms(28);
        push_mark(CMD_DRAIN);
        push_write(mp3s2_pkg::REG_CHANNEL_COUNT, 32'd1023);
        push_randoms(18);
        push_mark(CMD_DRAIN);

        // random settings, changed mid-plane too; oversized windows and zero outputs
        in_eff = 3;
        for (int ph = 0; ph < 12; ph++) begin
            wrote = 1'b0;
            if ($urandom_range(0, 2) != 0) begin
                in_eff = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 255)
                                                     : $urandom_range(3, 24);
                push_write(mp3s2_pkg::REG_IN_WIDTH, in_eff);
                wrote = 1'b1;
            end
            if (!wrote || ($urandom_range(0, 2) != 0)) begin
                fit = (in_eff - 1) / 2;
                case ($urandom_range(0, 9))
                    0:       outw = 0;
                    1:       outw = $urandom_range(0, 127);
                    default: outw = $urandom_range(1, fit);
                endcase
                push_write(mp3s2_pkg::REG_OUT_WIDTH, outw);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0:       push_write(mp3s2_pkg::REG_CHANNEL_COUNT, 32'd0);
                    1:       push_write(mp3s2_pkg::REG_CHANNEL_COUNT, 32'd1023);
                    default: push_write(mp3s2_pkg::REG_CHANNEL_COUNT, $urandom_range(1, 4));
                endcase
            end
            if (ph == 9) push_mark(CMD_CALM);
            push_randoms($urandom_range(10, 50));
            push_mark(CMD_DRAIN);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (feed_done);
        @(posedge i_clk);
        if (pooled_q.size() != 0) begin
            $display("%t: %0d pooled results never arrived", $time, pooled_q.size());
        end
        if (mismatches == 0 && pooled_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Input driver: pixel beats, register writes, drains, with random idle bursts
    int         feed_gap = 0;
    int         quiet = 0;
    t_apb_phase apb_step = APB_IDLE;

    always @(posedge i_clk) begin
        t_stim_cmd head;
        logic      nv;
        nv = 1'b0;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                cmdq.delete(0);
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                nv = 1'b1;  // beat must stay up until taken
            end else if (feed_gap != 0) begin
                feed_gap <= feed_gap - 1;
            end else if (cmdq.size() == 0) begin
                feed_done <= 1'b1;
            end else begin
                head = cmdq[0];
                case (head.kind)
                    CMD_PIXEL: begin
                        if (!calm && $urandom_range(0, 19) == 0) begin
                            feed_gap <= $urandom_range(0, 13);
                        end else begin
                            nv = 1'b1;
                            i_s_axis_tdata <= head.data;
                        end
                    end
                    CMD_DRAIN: begin
                        if (pooled_q.size() != 0) begin
                            quiet <= 0;
                        end else if (quiet >= DRAIN_CYCLES) begin
                            quiet <= 0;
                            cmdq.delete(0);
                        end else begin
                            quiet <= quiet + 1;
                        end
                    end
                    CMD_WRITE: begin
                        unique case (apb_step)
                            APB_IDLE: begin
                                psel <= 1'b1;
                                pwrite <= 1'b1;
                                paddr <= {head.reg_idx, 2'b00};
                                pwdata <= head.data;
                                apb_step <= APB_SETUP;
                            end
                            APB_SETUP: begin
                                penable <= 1'b1;
                                apb_step <= APB_ACCESS;
                            end
                            APB_ACCESS: begin
                                if (pready) begin
                                    psel <= 1'b0;
                                    penable <= 1'b0;
                                    pwrite <= 1'b0;
                                    apply_cfg(head.reg_idx, head.data);
                                    apb_step <= APB_IDLE;
                                    cmdq.delete(0);
                                end
                            end
                            default: apb_step <= APB_IDLE;
                        endcase
                    end
                    CMD_CALM: begin
                        calm <= 1'b1;
                        cmdq.delete(0);
                    end
                    default: cmdq.delete(0);
                endcase
            end
            i_s_axis_tvalid <= nv;
        end
    end

    // Output back-pressure in random bursts
    int sink_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap <= sink_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
            sink_gap <= $urandom_range(0, 13);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on every input beat, check every output beat
    always @(posedge i_clk) begin
        t_pooled want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pool_pixel(i_s_axis_tdata);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pooled_q.size() == 0) begin
                    mismatches++;
                    $display("%t: unexpected beat, expected none, got data %h last %b user %b",
                             $time, o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                end else begin
                    want = pooled_q.pop_front();
                    if (o_m_axis_tdata !== {1'b0, want.pooled}) begin
                        mismatches++;
                        $display("%t: pooled value expected %h got %h",
                                 $time, {1'b0, want.pooled}, o_m_axis_tdata);
                    end
                    if (o_m_axis_tlast !== want.end_of_plane) begin
                        mismatches++;
                        $display("%t: end of plane expected %b got %b",
                                 $time, want.end_of_plane, o_m_axis_tlast);
                    end
                    if (o_m_axis_tuser !== want.end_of_layer) begin
                        mismatches++;
                        $display("%t: end of layer expected %b got %b",
                                 $time, want.end_of_layer, o_m_axis_tuser);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat or register write
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (psel && penable && pready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%t: no progress for %0d cycles", $time, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
